>>> rtl/core/dlst_pkg.sv
package dlst_pkg;

    localparam int LEVEL_W    = 10;
    localparam int KNOB_W     = 10;
    localparam int STEP_W     = 10;
    localparam int UNIT_W     = 14;
    localparam int INTERVAL_W = 8;
    localparam int SECOND_W   = 16;
    localparam int TREND_W    = 2;

    localparam int KNOB_STEP  = 204;
    localparam int KNOB_MAX   = (1 << KNOB_W) - 1;
    localparam int QUOT_MAX   = KNOB_MAX / KNOB_STEP;
    localparam int QUOT_W     = $clog2(QUOT_MAX + 2);
    localparam int TIMEOUT_W  = QUOT_W + UNIT_W;
    localparam int CMP_W      = (TIMEOUT_W > SECOND_W) ? TIMEOUT_W : SECOND_W;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 14;

    localparam logic [LEVEL_W-1:0]    DARK_LEVEL_RST  = LEVEL_W'(300);
    localparam logic [LEVEL_W-1:0]    BRIGHT_LEVEL_RST = LEVEL_W'(30);
    localparam logic [STEP_W-1:0]     CHANGE_STEP_RST = STEP_W'(20);
    localparam logic [UNIT_W-1:0]     TIMEOUT_UNIT_RST = UNIT_W'(7224);
    localparam logic [INTERVAL_W-1:0] INTERVAL_RST    = INTERVAL_W'(59);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DARK_LEVEL   = 3'd0,
        REG_BRIGHT_LEVEL = 3'd1,
        REG_CHANGE_STEP  = 3'd2,
        REG_TIMEOUT_UNIT = 3'd3,
        REG_INTERVAL     = 3'd4
    } cfg_index_t;

    typedef enum logic [TREND_W-1:0] {
        TREND_NONE = 2'd0,
        TREND_RISE = 2'd1,
        TREND_FALL = 2'd2
    } trend_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]    dark_level;
        logic [LEVEL_W-1:0]    bright_level;
        logic [STEP_W-1:0]     change_step;
        logic [UNIT_W-1:0]     timeout_unit_secs;
        logic [INTERVAL_W-1:0] history_interval;
    } cfg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]   light_sample;
        logic [TIMEOUT_W-1:0] timeout;
    } tick_t;

    typedef struct packed {
        logic         lamp_on;
        logic [TREND_W-1:0] trend;
        logic         off_by_timeout;
    } result_t;

endpackage

>>> rtl/core/dlst_cfg_regs.sv
module dlst_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [dlst_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dlst_pkg::CFG_DATA_W-1:0]  cfg_data,
    output dlst_pkg::cfg_t                   cfg
);
    import dlst_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_DARK_LEVEL:   cfg_next.dark_level        = cfg_data[LEVEL_W-1:0];
                REG_BRIGHT_LEVEL: cfg_next.bright_level      = cfg_data[LEVEL_W-1:0];
                REG_CHANGE_STEP:  cfg_next.change_step       = cfg_data[STEP_W-1:0];
                REG_TIMEOUT_UNIT: cfg_next.timeout_unit_secs = cfg_data[UNIT_W-1:0];
                REG_INTERVAL:     cfg_next.history_interval  = cfg_data[INTERVAL_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dark_level        <= DARK_LEVEL_RST;
            cfg_reg.bright_level      <= BRIGHT_LEVEL_RST;
            cfg_reg.change_step       <= CHANGE_STEP_RST;
            cfg_reg.timeout_unit_secs <= TIMEOUT_UNIT_RST;
            cfg_reg.history_interval  <= INTERVAL_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/dlst_in_stage.sv
module dlst_in_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [dlst_pkg::LEVEL_W-1:0]  light_sample,
    input  logic [dlst_pkg::KNOB_W-1:0]   knob_sample,
    input  logic [dlst_pkg::UNIT_W-1:0]   timeout_unit_secs,
    input  logic                          take,
    output logic                          tick_valid,
    output dlst_pkg::tick_t               tick
);
    import dlst_pkg::*;

    logic                 valid_reg;
    logic                 valid_next;
    tick_t                tick_reg;
    logic [QUOT_W-1:0]    knob_quot;
    logic [TIMEOUT_W-1:0] timeout_calc;
    logic                 load;

    // The knob quotient is found by comparing against each multiple of the
    // knob step; the thresholds rise, so the last one passed gives the quotient.
    always_comb
    begin
        knob_quot = '0;
        for (int k = 1; k <= QUOT_MAX; k++)
        begin
            if (int'(knob_sample) >= k * KNOB_STEP)
            begin
                knob_quot = QUOT_W'(k);
            end
        end
    end

    // The on-time limit depends only on the knob and a static register, so it
    // is formed here and registered with the beat.
    assign timeout_calc = (TIMEOUT_W'(knob_quot) + TIMEOUT_W'(1))
                          * TIMEOUT_W'(timeout_unit_secs);

    assign in_ready = !valid_reg || take;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tick_reg.light_sample <= light_sample;
            tick_reg.timeout      <= timeout_calc;
        end
    end

    assign tick_valid = valid_reg;
    assign tick       = tick_reg;

endmodule

>>> rtl/core/dlst_core.sv
module dlst_core (
    input  logic              clk,
    input  logic              rst_n,
    input  dlst_pkg::cfg_t    cfg,
    input  logic              tick_valid,
    input  dlst_pkg::tick_t   tick,
    output logic              take,
    output logic              res_valid,
    input  logic              res_ready,
    output dlst_pkg::result_t res
);
    import dlst_pkg::*;

    logic [SECOND_W-1:0]   second_reg;
    logic [SECOND_W-1:0]   second_next;
    logic [INTERVAL_W-1:0] interval_reg;
    logic [INTERVAL_W-1:0] interval_next;
    logic [LEVEL_W-1:0]    recent_reg;
    logic [LEVEL_W-1:0]    recent_next;
    logic                  recent_inval_reg;
    logic                  recent_inval_next;
    logic [LEVEL_W-1:0]    older_reg;
    logic [LEVEL_W-1:0]    older_next;
    logic                  older_inval_reg;
    logic                  older_inval_next;
    logic                  lamp_reg;
    logic                  lamp_next;
    logic                  res_valid_reg;
    logic                  res_valid_next;
    result_t               res_reg;
    result_t               res_next;

    logic [SECOND_W-1:0]   second_inc;
    logic [INTERVAL_W-1:0] interval_dec;
    logic                  shift;
    logic [LEVEL_W-1:0]    hist_recent;
    logic                  hist_recent_inval;
    logic [LEVEL_W-1:0]    hist_older;
    logic                  hist_older_inval;
    logic signed [LEVEL_W:0] diff;
    logic signed [LEVEL_W:0] step_s;
    trend_t                trend;
    logic                  by_light;
    logic                  by_time;
    logic                  switch_on;
    logic                  switch_off;

    assign take = tick_valid && (!res_valid_reg || res_ready);

    assign second_inc   = second_reg + SECOND_W'(1);
    assign interval_dec = interval_reg - INTERVAL_W'(1);
    assign shift        = (interval_dec == '0);

    assign hist_recent       = shift ? tick.light_sample : recent_reg;
    assign hist_recent_inval = shift ? 1'b0 : recent_inval_reg;
    assign hist_older        = shift ? recent_reg : older_reg;
    assign hist_older_inval  = shift ? recent_inval_reg : older_inval_reg;

    assign diff   = $signed({1'b0, hist_recent}) - $signed({1'b0, hist_older});
    assign step_s = $signed({1'b0, cfg.change_step});

    always_comb
    begin
        priority if (hist_recent_inval || hist_older_inval)
        begin
            trend = TREND_NONE;
        end
        else if (diff >= step_s)
        begin
            trend = TREND_RISE;
        end
        else if (diff <= -step_s)
        begin
            trend = TREND_FALL;
        end
        else
        begin
            trend = TREND_NONE;
        end
    end

    assign by_light   = (trend == TREND_FALL) && (tick.light_sample < cfg.bright_level);
    assign by_time    = CMP_W'(second_inc) >= CMP_W'(tick.timeout);
    assign switch_on  = !lamp_reg && (trend == TREND_RISE)
                        && (tick.light_sample > cfg.dark_level);
    assign switch_off = lamp_reg && (by_light || by_time);

    always_comb
    begin
        second_next       = second_reg;
        interval_next     = interval_reg;
        recent_next       = recent_reg;
        recent_inval_next = recent_inval_reg;
        older_next        = older_reg;
        older_inval_next  = older_inval_reg;
        lamp_next         = lamp_reg;
        res_next          = res_reg;
        res_valid_next    = res_valid_reg && !res_ready;

        if (take)
        begin
            second_next       = switch_on ? '0 : second_inc;
            interval_next     = shift ? cfg.history_interval : interval_dec;
            recent_next       = hist_recent;
            recent_inval_next = hist_recent_inval || switch_on || switch_off;
            older_next        = hist_older;
            older_inval_next  = hist_older_inval || switch_on || switch_off;
            lamp_next         = (lamp_reg && !switch_off) || switch_on;

            res_valid_next         = 1'b1;
            res_next.lamp_on       = lamp_next;
            res_next.trend         = trend;
            res_next.off_by_timeout = switch_off && by_time;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            second_reg       <= '0;
            interval_reg     <= INTERVAL_RST;
            recent_reg       <= '0;
            recent_inval_reg <= 1'b0;
            older_reg        <= '0;
            older_inval_reg  <= 1'b0;
            lamp_reg         <= 1'b0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            second_reg       <= second_next;
            interval_reg     <= interval_next;
            recent_reg       <= recent_next;
            recent_inval_reg <= recent_inval_next;
            older_reg        <= older_next;
            older_inval_reg  <= older_inval_next;
            lamp_reg         <= lamp_next;
            res_valid_reg    <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

>>> rtl/core/dusk_light_switch_with_timeout.sv
// Path: an accepted beat waits in the input register; the combinational tick
// logic then writes its result into the result register. Throughput: one beat
// per cycle while the result side is ready; each register holds one beat.
// Reset: rst_n clears the lamp, counters and history and loads register
// defaults asynchronously; no clearing pass is needed.
module dusk_light_switch_with_timeout (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [dlst_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dlst_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [23:0]                      s_axis_tdata, // light_sample, knob_sample
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [7:0]                       m_axis_tdata  // lamp_on, trend, off_by_timeout
);
    import dlst_pkg::*;

    cfg_t    cfg;
    logic    tick_valid;
    tick_t   tick;
    logic    take;
    result_t res;

    dlst_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dlst_in_stage u_in_stage (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (s_axis_tvalid),
        .in_ready          (s_axis_tready),
        .light_sample      (s_axis_tdata[LEVEL_W-1:0]),
        .knob_sample       (s_axis_tdata[LEVEL_W+KNOB_W-1:LEVEL_W]),
        .timeout_unit_secs (cfg.timeout_unit_secs),
        .take              (take),
        .tick_valid        (tick_valid),
        .tick              (tick)
    );

    dlst_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .tick_valid (tick_valid),
        .tick       (tick),
        .take       (take),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready),
        .res        (res)
    );

    assign m_axis_tdata = {4'b0000, res.off_by_timeout, res.trend, res.lamp_on};

endmodule

>>> tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dlst_pkg::*;

    localparam logic [SECOND_W-1:0] HIST_INVALID = '1;
    localparam int LEVEL_MAX = (1 << LEVEL_W) - 1;

    typedef struct packed {
        logic   lamp_on;
        trend_t trend;
        logic   off_by_timeout;
    } lamp_status_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [23:0]            s_axis_tdata; // light_sample, knob_sample
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [7:0]             m_axis_tdata; // lamp_on, trend, off_by_timeout

    // Thresholds and timing as the block should hold them.
    logic [LEVEL_W-1:0]    dark_thr;
    logic [LEVEL_W-1:0]    bright_thr;
    logic [STEP_W-1:0]     step_thr;
    logic [UNIT_W-1:0]     unit_secs;
    logic [INTERVAL_W-1:0] shift_period;

    // Lamp, counters and light history as the block should hold them.
    logic [SECOND_W-1:0]   seconds_on;
    logic [INTERVAL_W-1:0] shift_countdown;
    logic [SECOND_W-1:0]   level_new;
    logic [SECOND_W-1:0]   level_old;
    logic                  lamp_lit;

    lamp_status_t expected_status[$];
    int           err_count;
    int           walk_light;
    bit           tx_no_gap;
    bit           rx_no_stall;
    int           rx_hold_cycles;

    dusk_light_switch_with_timeout dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic lamp_status_t predict_tick(input logic [LEVEL_W-1:0] light,
                                                  input logic [KNOB_W-1:0] knob);
        lamp_status_t st;
        int           diff;
        int unsigned  limit;
        logic         by_light;
        logic         by_time;
        seconds_on = seconds_on + SECOND_W'(1);
        shift_countdown = shift_countdown - INTERVAL_W'(1);
        if (shift_countdown == '0)
        begin
            shift_countdown = shift_period;
            level_old = level_new;
            level_new = SECOND_W'(light);
        end
        st.trend = TREND_NONE;
        if (level_new != HIST_INVALID && level_old != HIST_INVALID)
        begin
            diff = int'(level_new) - int'(level_old);
            if (diff >= int'(step_thr))
                st.trend = TREND_RISE;
            else if (diff <= -int'(step_thr))
                st.trend = TREND_FALL;
        end
        limit = (int'(knob) / KNOB_STEP + 1) * int'(unit_secs);
        st.off_by_timeout = 1'b0;
        if (!lamp_lit)
        begin
            if (st.trend == TREND_RISE && light > dark_thr)
            begin
                lamp_lit = 1'b1;
                seconds_on = '0;
                level_new = HIST_INVALID;
                level_old = HIST_INVALID;
            end
        end
        else
        begin
            by_light = (st.trend == TREND_FALL) && (light < bright_thr);
            by_time = (32'(seconds_on) >= limit);
            if (by_light || by_time)
            begin
                lamp_lit = 1'b0;
                st.off_by_timeout = by_time;
                level_new = HIST_INVALID;
                level_old = HIST_INVALID;
            end
        end
        st.lamp_on = lamp_lit;
        return st;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            expected_status.push_back(predict_tick(s_axis_tdata[LEVEL_W-1:0],
                                                   s_axis_tdata[LEVEL_W +: KNOB_W]));
    end

    always @(posedge clk)
    begin
        lamp_status_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_status.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, actual %h",
                         $time, m_axis_tdata);
                err_count++;
            end
            else
            begin
                want = expected_status.pop_front();
                if (m_axis_tdata[0] !== want.lamp_on)
                begin
                    $display("%0t: lamp_on expected %0d actual %0d",
                             $time, want.lamp_on, m_axis_tdata[0]);
                    err_count++;
                end
                if (m_axis_tdata[2:1] !== want.trend)
                begin
                    $display("%0t: trend expected %0d actual %0d",
                             $time, want.trend, m_axis_tdata[2:1]);
                    err_count++;
                end
                if (m_axis_tdata[3] !== want.off_by_timeout)
                begin
                    $display("%0t: off_by_timeout expected %0d actual %0d",
                             $time, want.off_by_timeout, m_axis_tdata[3]);
                    err_count++;
                end
            end
        end
    end

    initial
    begin
        int stall;
        forever
        begin
            if (rx_hold_cycles != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge clk);
                rx_hold_cycles = 0;
            end
            stall = rx_no_stall ? 0 : $urandom_range(0, 7);
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    initial
    begin
        #5ms;
        $display("tb failed");
        $finish;
    end

    task automatic send_tick(input logic [LEVEL_W-1:0] light, input logic [KNOB_W-1:0] knob);
        int gap;
        gap = tx_no_gap ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, knob, light};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_status.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input int unsigned value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        case (index)
            REG_DARK_LEVEL:   dark_thr = LEVEL_W'(value);
            REG_BRIGHT_LEVEL: bright_thr = LEVEL_W'(value);
            REG_CHANGE_STEP:  step_thr = STEP_W'(value);
            REG_TIMEOUT_UNIT: unit_secs = UNIT_W'(value);
            REG_INTERVAL:     shift_period = INTERVAL_W'(value);
            default:          ;
        endcase
    endtask

    task automatic set_levels(input int unsigned dark, input int unsigned bright,
                              input int unsigned step, input int unsigned unit,
                              input int unsigned interval);
        wait_idle();
        write_reg(REG_DARK_LEVEL, dark);
        write_reg(REG_BRIGHT_LEVEL, bright);
        write_reg(REG_CHANGE_STEP, step);
        write_reg(REG_TIMEOUT_UNIT, unit);
        write_reg(REG_INTERVAL, interval);
    endtask

    // Random walk that mostly ramps by at least one change step so trends form.
    function automatic logic [LEVEL_W-1:0] next_light(input int step);
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = walk_light + step + int'($urandom_range(0, 40));
            4, 5, 6:    v = walk_light - step - int'($urandom_range(0, 40));
            7:          v = walk_light;
            default:    v = int'($urandom_range(0, LEVEL_MAX));
        endcase
        if (v < 0)
            v = 0;
        if (v > LEVEL_MAX)
            v = LEVEL_MAX;
        walk_light = v;
        return LEVEL_W'(v);
    endfunction

    task automatic test_reset_defaults();
        send_tick(10'd0, 10'd0);
        send_tick(10'h3FF, 10'h3FF);
        send_tick(10'h155, 10'h2AA);
        send_tick(10'h2AA, 10'h155);
    endtask

    task automatic test_switch_on_and_timeout();
        set_levels(300, 30, 20, 1, 1);
        send_tick(10'd100, 10'd0);
        send_tick(10'd400, 10'd0);
        send_tick(10'd500, 10'd0);
        send_tick(10'd600, 10'h3FF);
    endtask

    task automatic test_light_off_and_both();
        set_levels(300, 30, 20, 2, 1);
        send_tick(10'd100, 10'd0);
        send_tick(10'd400, 10'd0);
        send_tick(10'd500, 10'd0);
        send_tick(10'd10, 10'd0);
        wait_idle();
        write_reg(REG_TIMEOUT_UNIT, 100);
        send_tick(10'd100, 10'd0);
        send_tick(10'd400, 10'd0);
        send_tick(10'd500, 10'd0);
        send_tick(10'd10, 10'd0);
    endtask

    task automatic test_zero_step_and_unit();
        set_levels(300, 30, 0, 0, 1);
        send_tick(10'd500, 10'd0);
        send_tick(10'd500, 10'd0);
        send_tick(10'd500, 10'd0);
        wait_idle();
        write_reg(REG_TIMEOUT_UNIT, (1 << UNIT_W) - 1);
        send_tick(10'd500, 10'h3FF);
        send_tick(10'd600, 10'h3FF);
        send_tick(10'd700, 10'h3FF);
    endtask

    task automatic test_unused_index();
        wait_idle();
        for (int i = REG_INTERVAL + 1; i < (1 << CFG_INDEX_W); i++)
            write_reg(CFG_INDEX_W'(i), (1 << CFG_DATA_W) - 1);
        send_tick(10'd0, 10'd0);
        send_tick(10'h3FF, 10'h3FF);
    endtask

    task automatic run_lamp_phase(input int unsigned dark, input int unsigned bright,
                                  input int unsigned step, input int unsigned unit,
                                  input int unsigned interval, input int count);
        set_levels(dark, bright, step, unit, interval);
        for (int i = 0; i < count; i++)
        begin
            if (i % 50 == 0)
            begin
                tx_no_gap = ($urandom_range(0, 3) == 0);
                rx_no_stall = ($urandom_range(0, 3) == 0);
            end
            send_tick(next_light(int'(step)), KNOB_W'($urandom_range(0, KNOB_MAX)));
        end
        tx_no_gap = 1'b0;
        rx_no_stall = 1'b0;
    endtask

    task automatic test_random_mix();
        run_lamp_phase(300, 30, 20, 5, 1, 250);
        run_lamp_phase(0, LEVEL_MAX, 1, 1, 2, 200);
        run_lamp_phase(LEVEL_MAX, 0, LEVEL_MAX, (1 << UNIT_W) - 1, 255, 100);
        run_lamp_phase(0, 0, 0, 0, 0, 300);
        repeat (4)
            run_lamp_phase($urandom_range(0, 700), $urandom_range(100, LEVEL_MAX),
                           $urandom_range(0, 80), $urandom_range(0, 60),
                           $urandom_range(1, 4), 200);
    endtask

    task automatic test_output_backpressure();
        set_levels(300, 30, 20, 10000, 1);
        tx_no_gap = 1'b1;
        rx_hold_cycles = 50;
        for (int i = 0; i < 40; i++)
            send_tick(next_light(20), KNOB_W'($urandom_range(0, KNOB_MAX)));
        tx_no_gap = 1'b0;
    endtask

    task automatic test_drain_pause();
        set_levels(200, 300, 10, 8, 1);
        repeat (3)
        begin
            for (int i = 0; i < 12; i++)
                send_tick(next_light(10), KNOB_W'($urandom_range(0, KNOB_MAX)));
            wait_idle();
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_index     <= REG_DARK_LEVEL;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        dark_thr        = DARK_LEVEL_RST;
        bright_thr      = BRIGHT_LEVEL_RST;
        step_thr        = CHANGE_STEP_RST;
        unit_secs       = TIMEOUT_UNIT_RST;
        shift_period    = INTERVAL_RST;
        seconds_on      = '0;
        shift_countdown = INTERVAL_RST;
        level_new       = '0;
        level_old       = '0;
        lamp_lit        = 1'b0;
        walk_light      = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_switch_on_and_timeout();
        test_light_off_and_both();
        test_zero_step_and_unit();
        test_unused_index();
        test_random_mix();
        test_output_backpressure();
        test_drain_pause();

        wait_idle();
        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
